FILE: rtl/tslm_pkg.sv
// Shared types and constants for the two-way sorted line merge.
package tslm_pkg;

    localparam int LINE_BYTES_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int KEY_W           = 7;
    localparam logic [KEY_W-1:0] KEY_LEN_RST = 7'd64;
    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       port;
        logic [7:0] data;
        logic       is_nl;
    } t_item;

endpackage

FILE: rtl/two_way_sorted_line_merge_core.sv
// Top level of the two-way sorted line merge: input queue and merge sequencer.
// Merges two sorted byte streams line by line. A line closes at a newline (kept), at
// LINE_BYTES bytes, or when its port ends; once each port holds a complete line or has
// ended, the line with the smaller key (first key_len bytes, unsigned, ties to port 0)
// is sent byte by byte with tlast on its final byte. An input transaction that causes no
// output passes through the sequencer's fetch, buffer update and merge check steps. A line
// emission adds a selection step, a read and a compare step per compared key byte when both
// ports hold a line (plus a final check when the whole key ties), a read and a write step per
// line byte and any wait of the output for tready; a line that goes out before its transaction
// is applied skips the merge check. The single sequencer steps through the line buffer memory
// one registered read at a time. A queue of QUEUE_DEPTH transactions in front of it and a
// registered output keep both sides flowing.
module two_way_sorted_line_merge_core #(
    parameter int LINE_BYTES  = tslm_pkg::LINE_BYTES_DEF,
    parameter int QUEUE_DEPTH = tslm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]                 s_axis_tuser,   // [0] kind, [1] port
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tuser,   // [0] from_port
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [tslm_pkg::KEY_W-1:0] i_cfg_wdata
);
    import tslm_pkg::*;

    logic  item_valid;
    logic  item_ready;
    t_item item;

    tslm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_kind       (s_axis_tuser[0]),
        .i_port       (s_axis_tuser[1]),
        .i_data       (s_axis_tdata),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    tslm_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (m_axis_tdata),
        .o_out_port   (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

FILE: rtl/tslm_front.sv
// Input queue: accepts stream transactions, classifies them and buffers them for the back end.
module tslm_front #(
    parameter int DEPTH = tslm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_kind,
    input  logic           i_port,
    input  logic [7:0]     i_data,
    output logic           o_item_valid,
    input  logic           i_item_ready,
    output tslm_pkg::t_item o_item
);
    import tslm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item          r_q [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;
    t_item          in_item;

    always_comb begin
        in_item.kind  = i_kind;
        in_item.port  = i_port;
        in_item.data  = i_data;
        in_item.is_nl = (i_kind == KIND_DATA) && (i_data == NEWLINE);
    end

    assign o_ready      = (r_count != CNT_FULL);
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/tslm_back.sv
// Merge sequencer: line buffers, key compare, byte emission and output register.
module tslm_back #(
    parameter int LINE_BYTES = tslm_pkg::LINE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    input  tslm_pkg::t_item            i_item,
    input  logic                       i_cfg_we,
    input  logic [tslm_pkg::KEY_W-1:0] i_cfg_wdata,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_port,
    output logic                       o_out_last
);
    import tslm_pkg::*;

    localparam int IW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LW    = $clog2(LINE_BYTES + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 << IW;
    localparam logic [LW-1:0]    LEN_MAX  = LW'(LINE_BYTES);
    localparam logic [KEY_W-1:0] KEY_MAX  = KEY_W'(LINE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_APPLY, S_CHK, S_SEL, S_CMP_RD, S_CMP_EV, S_EMIT_RD, S_EMIT_WR
    } t_state;

    t_state            r_state;
    t_item             r_item;
    logic              r_pend;
    logic              r_post;
    logic              r_win;
    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     r_len [2];
    logic [1:0]        r_cmpl;
    logic [1:0]        r_end;
    logic [KEY_W-1:0]  r_key_len;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_port;
    logic              r_out_last;
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd0;
    logic [7:0]        r_rd1;

    logic              ready_now;
    logic [LW-1:0]     key_n;
    logic [AW-1:0]     rd_addr0;
    logic [AW-1:0]     rd_addr1;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        key0;
    logic [7:0]        key1;
    logic              ap_p;
    logic [LW-1:0]     ap_len;
    logic [LW-1:0]     ap_len_inc;
    logic              wr_ok;
    logic              mem_we;
    logic [LW-1:0]     idx_inc;
    logic              emit_last;
    logic              emitting;
    logic              out_free;

    always_comb begin
        ready_now  = (r_cmpl[0] | r_end[0]) & (r_cmpl[1] | r_end[1]) & (r_cmpl[0] | r_cmpl[1]);
        key_n      = (r_key_len > KEY_MAX) ? LEN_MAX : LW'(r_key_len);
        emitting   = (r_state == S_EMIT_RD) || (r_state == S_EMIT_WR);
        rd_addr0   = {(emitting ? r_win : 1'b0), r_idx[IW-1:0]};
        rd_addr1   = {1'b1, r_idx[IW-1:0]};
        key0       = (r_idx < r_len[0]) ? r_rd0 : 8'd0;
        key1       = (r_idx < r_len[1]) ? r_rd1 : 8'd0;
        ap_p       = r_item.port;
        ap_len     = r_len[ap_p];
        ap_len_inc = ap_len + LW'(1);
        wr_ok      = (r_item.kind == KIND_DATA) && !r_end[ap_p] && !r_cmpl[ap_p]
                     && (ap_len < LEN_MAX);
        mem_we     = (r_state == S_APPLY) && wr_ok;
        wr_addr    = {ap_p, ap_len[IW-1:0]};
        idx_inc    = r_idx + LW'(1);
        emit_last  = (idx_inc == r_len[r_win]);
        out_free   = !r_out_valid || i_out_ready;
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_port   = r_out_port;
    assign o_out_last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_item.data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_post      <= 1'b0;
            r_win       <= 1'b0;
            r_idx       <= '0;
            r_len[0]    <= '0;
            r_len[1]    <= '0;
            r_cmpl      <= '0;
            r_end       <= '0;
            r_key_len   <= KEY_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_len <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && (r_state != S_EMIT_WR)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        if (ready_now) begin
                            r_pend  <= 1'b1;
                            r_post  <= 1'b0;
                            r_state <= S_SEL;
                        end else begin
                            r_pend  <= 1'b0;
                            r_post  <= 1'b1;
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    if (r_item.kind == KIND_END) begin
                        if (!r_end[ap_p]) begin
                            if ((ap_len != '0) && !r_cmpl[ap_p]) begin
                                r_cmpl[ap_p] <= 1'b1;
                            end
                            r_end[ap_p] <= 1'b1;
                        end
                    end else if (wr_ok) begin
                        r_len[ap_p] <= ap_len_inc;
                        if (r_item.is_nl || (ap_len_inc == LEN_MAX)) begin
                            r_cmpl[ap_p] <= 1'b1;
                        end
                    end
                    r_state <= r_post ? S_CHK : S_IDLE;
                end
                S_CHK: begin
                    if (ready_now) begin
                        r_pend  <= 1'b0;
                        r_state <= S_SEL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SEL: begin
                    r_idx <= '0;
                    if (r_cmpl[0] && r_cmpl[1]) begin
                        r_state <= S_CMP_RD;
                    end else begin
                        r_win   <= !r_cmpl[0];
                        r_state <= S_EMIT_RD;
                    end
                end
                S_CMP_RD: begin
                    if (r_idx == key_n) begin
                        r_win   <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_state <= S_CMP_EV;
                    end
                end
                S_CMP_EV: begin
                    priority if (key1 < key0) begin
                        r_win   <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (key1 > key0) begin
                        r_win   <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= S_CMP_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_rd0;
                        r_out_port  <= r_win;
                        r_out_last  <= emit_last;
                        if (emit_last) begin
                            r_len[r_win]  <= '0;
                            r_cmpl[r_win] <= 1'b0;
                            r_post        <= 1'b0;
                            r_state       <= r_pend ? S_APPLY : S_IDLE;
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
